### rtl/bthin_pkg.sv
// ----------------------------------------------------------------------------
// bthin_pkg
// Shared types and constants of the binary image thinning unit.
// ----------------------------------------------------------------------------
package bthin_pkg;

	localparam int MAX_WIDTH  = 256;
	localparam int MAX_HEIGHT = 256;
	localparam int ADDR_W     = 16;
	localparam int DIM_W      = 9;
	localparam int CFG_IDX_W  = 2;

	localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_WIDTH);

	typedef enum logic [1:0] {
		CMD_WRITE  = 2'd0,
		CMD_THIN   = 2'd1,
		CMD_READ   = 2'd2,
		CMD_UNUSED = 2'd3
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_RSVD2  = 2'd2,
		REG_RSVD3  = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] row;
		logic [7:0] col;
		logic [7:0] pixel_in;
	} in_t;

	typedef struct packed {
		logic [7:0]  pixel_out;
		logic [15:0] pair_count;
	} out_t;

endpackage

### rtl/bthin_ram.sv
// ----------------------------------------------------------------------------
// bthin_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module bthin_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/binary_image_thinning_unit.sv
// ----------------------------------------------------------------------------
// binary_image_thinning_unit
// Zhang-Suen thinning of a binary image held in a 256 x 256 bit frame store.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. Every command gives
// exactly one response on rsp, marked by a one-cycle done strobe; the
// receiver cannot hold it off.
// Write and read commands may follow back to back; the response appears in
// the cycle after the command.
// A thin command raises busy until it finishes. Each sub-pass makes a mark
// sweep over the interior pixels (eight neighbor reads per pixel through the
// one read port of the frame memory) and a delete sweep over the interior
// pixels. Every pair ends with a bookkeeping step, and after the first pair
// a check sweep over the active pixels looks for any foreground. With w and h
// the effective dimensions, an image without an interior (w or h below 3)
// keeps only the bookkeeping steps and the check.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) is
// always ready; writes belong between commands.
// Reset returns the dimensions to 256 x 256 and clears the pair count; the
// frame store itself is not cleared and must be written before use.
// ----------------------------------------------------------------------------
module binary_image_thinning_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  bthin_pkg::in_t                  req,
	output logic                            done,
	output bthin_pkg::out_t                 rsp,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [bthin_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bthin_pkg::DIM_W-1:0]     cfg_data
);

	import bthin_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MARK,
		S_DEL,
		S_PAIR,
		S_CHK
	} state_t;

	state_t             state_q;
	logic [DIM_W-1:0]   width_q, height_q;
	logic [DIM_W-1:0]   w_eff, h_eff;
	logic [7:0]         r_q, c_q;
	logic [3:0]         k_q;
	logic               ph_q;
	logic [6:0]         nb_q;
	logic               second_q, first_q, removed_q, nonempty_q;
	logic [15:0]        pairs_q;
	logic               done_q, rdsel_q;
	logic               interior_ok, last_c, last_r;
	logic [DIM_W-1:0]   c_end, r_end;
	logic               accept, in_area;
	logic [7:0]         n_all;
	logic               mark_bit;

	logic               f_we, m_we, f_wdata;
	logic [ADDR_W-1:0]  f_waddr, f_raddr, m_raddr, pix_addr;
	logic               f_rdata, m_rdata;

	function automatic logic [ADDR_W-1:0] nbr_addr(input logic [7:0] r,
		input logic [7:0] c, input logic [2:0] k);
		logic [7:0] rr, cc;
		begin
			rr = r;
			cc = c;
			unique case (k)
				3'd0: begin rr = r - 8'd1; end
				3'd1: begin rr = r - 8'd1; cc = c + 8'd1; end
				3'd2: begin cc = c + 8'd1; end
				3'd3: begin rr = r + 8'd1; cc = c + 8'd1; end
				3'd4: begin rr = r + 8'd1; end
				3'd5: begin rr = r + 8'd1; cc = c - 8'd1; end
				3'd6: begin cc = c - 8'd1; end
				3'd7: begin rr = r - 8'd1; cc = c - 8'd1; end
				default: begin rr = r; end
			endcase
			return {rr, cc};
		end
	endfunction

	// Zhang-Suen deletion test on the eight neighbors, north first, clockwise.
	function automatic logic zs_mark(input logic [7:0] n, input logic second);
		logic [3:0] trans, cnt;
		logic       m1, m2;
		begin
			trans = '0;
			cnt   = '0;
			for (int k = 0; k < 8; k++) begin
				cnt = cnt + 4'(n[k]);
				if (!n[k] && n[(k + 1) % 8]) begin
					trans = trans + 4'd1;
				end
			end
			if (!second) begin
				m1 = n[0] & n[2] & n[4];
				m2 = n[2] & n[4] & n[6];
			end else begin
				m1 = n[0] & n[2] & n[6];
				m2 = n[0] & n[4] & n[6];
			end
			return (trans == 4'd1) && (cnt >= 4'd2) && (cnt <= 4'd6) && !m1 && !m2;
		end
	endfunction

	assign w_eff       = (width_q > DIM_MAX) ? DIM_MAX : width_q;
	assign h_eff       = (height_q > DIM_MAX) ? DIM_MAX : height_q;
	assign interior_ok = (w_eff >= DIM_W'(3)) && (h_eff >= DIM_W'(3));
	assign busy        = (state_q != S_IDLE);
	assign accept      = start && !busy;
	assign in_area     = ({1'b0, req.row} < h_eff) && ({1'b0, req.col} < w_eff);
	assign cfg_ready   = 1'b1;

	assign c_end  = (state_q == S_CHK) ? (w_eff - DIM_W'(1)) : (w_eff - DIM_W'(2));
	assign r_end  = (state_q == S_CHK) ? (h_eff - DIM_W'(1)) : (h_eff - DIM_W'(2));
	assign last_c = ({1'b0, c_q} == c_end);
	assign last_r = ({1'b0, r_q} == r_end);

	assign pix_addr = {r_q, c_q};
	assign n_all    = {f_rdata, nb_q};
	assign mark_bit = zs_mark(n_all, second_q);

	always_comb begin
		f_we    = 1'b0;
		f_waddr = {req.row, req.col};
		f_wdata = (req.pixel_in == 8'hFF);
		f_raddr = {req.row, req.col};
		m_we    = 1'b0;
		m_raddr = pix_addr;
		unique case (state_q)
			S_IDLE: begin
				f_we = accept && (req.cmd == CMD_WRITE) && in_area;
			end
			S_MARK: begin
				f_raddr = nbr_addr(r_q, c_q, k_q[2:0]);
				m_we    = (k_q == 4'd8);
			end
			S_DEL: begin
				f_raddr = pix_addr;
				f_waddr = pix_addr;
				f_wdata = 1'b0;
				f_we    = ph_q && f_rdata && m_rdata;
			end
			S_CHK: begin
				f_raddr = pix_addr;
			end
			default: begin
				f_raddr = pix_addr;
			end
		endcase
	end

	bthin_ram #(.WIDTH(1), .DEPTH(MAX_WIDTH * MAX_HEIGHT)) u_frame (
		.clk  (clk),
		.we   (f_we),
		.waddr(f_waddr),
		.wdata(f_wdata),
		.raddr(f_raddr),
		.rdata(f_rdata)
	);

	bthin_ram #(.WIDTH(1), .DEPTH(MAX_WIDTH * MAX_HEIGHT)) u_marks (
		.clk  (clk),
		.we   (m_we),
		.waddr(pix_addr),
		.wdata(mark_bit),
		.raddr(m_raddr),
		.rdata(m_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_MAX;
			height_q <= DIM_MAX;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_WIDTH) begin
				width_q <= cfg_data;
			end else if (cfg_index == REG_HEIGHT) begin
				height_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			r_q        <= '0;
			c_q        <= '0;
			k_q        <= '0;
			ph_q       <= 1'b0;
			nb_q       <= '0;
			second_q   <= 1'b0;
			first_q    <= 1'b0;
			removed_q  <= 1'b0;
			nonempty_q <= 1'b0;
			pairs_q    <= '0;
			done_q     <= 1'b0;
			rdsel_q    <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					done_q  <= accept && (req.cmd != CMD_THIN);
					rdsel_q <= accept && (req.cmd == CMD_READ) && in_area;
					if (accept && (req.cmd == CMD_THIN)) begin
						pairs_q   <= '0;
						first_q   <= 1'b1;
						removed_q <= 1'b0;
						second_q  <= 1'b0;
						r_q       <= 8'd1;
						c_q       <= 8'd1;
						k_q       <= '0;
						state_q   <= interior_ok ? S_MARK : S_PAIR;
					end
				end
				S_MARK: begin
					done_q  <= 1'b0;
					rdsel_q <= 1'b0;
					if (k_q != 4'd0 && k_q != 4'd8) begin
						nb_q[k_q[2:0] - 3'd1] <= f_rdata;
					end
					if (k_q == 4'd8) begin
						k_q <= '0;
						if (last_c) begin
							c_q <= 8'd1;
							if (last_r) begin
								r_q     <= 8'd1;
								ph_q    <= 1'b0;
								state_q <= S_DEL;
							end else begin
								r_q <= r_q + 8'd1;
							end
						end else begin
							c_q <= c_q + 8'd1;
						end
					end else begin
						k_q <= k_q + 4'd1;
					end
				end
				S_DEL: begin
					done_q  <= 1'b0;
					rdsel_q <= 1'b0;
					ph_q    <= !ph_q;
					if (ph_q) begin
						if (f_rdata && m_rdata) begin
							removed_q <= 1'b1;
						end
						if (last_c) begin
							c_q <= 8'd1;
							if (last_r) begin
								r_q <= 8'd1;
								k_q <= '0;
								if (second_q) begin
									state_q <= S_PAIR;
								end else begin
									second_q <= 1'b1;
									state_q  <= S_MARK;
								end
							end else begin
								r_q <= r_q + 8'd1;
							end
						end else begin
							c_q <= c_q + 8'd1;
						end
					end
				end
				S_PAIR: begin
					rdsel_q <= 1'b0;
					if (pairs_q != 16'hFFFF) begin
						pairs_q <= pairs_q + 16'd1;
					end
					ph_q       <= 1'b0;
					nonempty_q <= 1'b0;
					k_q        <= '0;
					second_q   <= 1'b0;
					if (first_q && w_eff != '0 && h_eff != '0) begin
						r_q     <= '0;
						c_q     <= '0;
						done_q  <= 1'b0;
						state_q <= S_CHK;
					end else if (!first_q && removed_q) begin
						removed_q <= 1'b0;
						r_q       <= 8'd1;
						c_q       <= 8'd1;
						done_q    <= 1'b0;
						state_q   <= interior_ok ? S_MARK : S_PAIR;
					end else begin
						r_q     <= '0;
						c_q     <= '0;
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_CHK: begin
					rdsel_q <= 1'b0;
					done_q  <= ph_q && last_c && last_r && !nonempty_q && !f_rdata;
					ph_q    <= !ph_q;
					if (ph_q) begin
						if (f_rdata) begin
							nonempty_q <= 1'b1;
						end
						if (last_c) begin
							if (last_r) begin
								first_q   <= 1'b0;
								removed_q <= 1'b0;
								r_q       <= 8'd1;
								c_q       <= 8'd1;
								// Only a nonempty image earns a second pair.
								if (nonempty_q || f_rdata) begin
									state_q <= interior_ok ? S_MARK : S_PAIR;
								end else begin
									state_q <= S_IDLE;
								end
							end else begin
								c_q <= '0;
								r_q <= r_q + 8'd1;
							end
						end else begin
							c_q <= c_q + 8'd1;
						end
					end
				end
				default: begin
					done_q  <= 1'b0;
					rdsel_q <= 1'b0;
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done           = done_q;
	assign rsp.pixel_out  = (rdsel_q && f_rdata) ? 8'hFF : 8'h00;
	assign rsp.pair_count = pairs_q;

`ifndef ASSERT_OFF
	a_thin_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && req.cmd == CMD_THIN) |=> busy)
		else $error("thin command did not raise busy");

	a_pixel_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (rsp.pixel_out == 8'h00 || rsp.pixel_out == 8'hFF))
		else $error("pixel response not 0 or 255");

	a_mark_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MARK) |-> (k_q <= 4'd8))
		else $error("neighbor step counter out of range");

	a_no_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(busy && $past(busy)) |-> !done)
		else $error("response while thinning in progress");
`endif

endmodule
